>>> design/cpu16_microop_datapath_assert.svh
// ----------------------------------------------------------------------------
// cpu16 micro-op datapath assertion macros
// Concurrent check wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CPU16_MICROOP_DATAPATH_ASSERT_SVH
`define CPU16_MICROOP_DATAPATH_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define CPU16_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpu16 datapath: same-cycle check failed");

// next-cycle implication
`define CPU16_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpu16 datapath: next-cycle check failed");

`else

`define CPU16_ASSERT_NOW(label, clk, rst, ante, cons)
`define CPU16_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/cpu16_uop_pkg.sv
// ----------------------------------------------------------------------------
// cpu16 micro-op datapath package
// Word types, micro-op codes, selector codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpu16_uop_pkg;

  // micro-op codes
  localparam logic [4:0] FN_NONE    = 5'd0;
  localparam logic [4:0] FN_LOADREG = 5'd1;
  localparam logic [4:0] FN_BRCOND  = 5'd2;
  localparam logic [4:0] FN_BRANCH  = 5'd3;
  localparam logic [4:0] FN_SETADDR = 5'd4;
  localparam logic [4:0] FN_MODADDR = 5'd5;
  localparam logic [4:0] FN_MODSP   = 5'd6;
  localparam logic [4:0] FN_MODPC   = 5'd7;
  localparam logic [4:0] FN_INCDEC  = 5'd8;
  localparam logic [4:0] FN_SETFLAG = 5'd9;
  localparam logic [4:0] FN_MASK    = 5'd10;
  localparam logic [4:0] FN_XCE     = 5'd11;
  localparam logic [4:0] FN_XFER    = 5'd12;
  localparam logic [4:0] FN_PCADDR  = 5'd13;
  localparam logic [4:0] FN_ADDRPC  = 5'd14;
  localparam logic [4:0] FN_ALU8    = 5'd15;
  localparam logic [4:0] FN_ALU16   = 5'd16;

  // register selectors
  localparam logic [3:0] RG_A   = 4'd0;
  localparam logic [3:0] RG_X   = 4'd1;
  localparam logic [3:0] RG_Y   = 4'd2;
  localparam logic [3:0] RG_SP  = 4'd3;
  localparam logic [3:0] RG_DP  = 4'd4;
  localparam logic [3:0] RG_DBR = 4'd5;
  localparam logic [3:0] RG_PBR = 4'd6;
  localparam logic [3:0] RG_PCL = 4'd7;
  localparam logic [3:0] RG_PCH = 4'd8;
  localparam logic [3:0] RG_P   = 4'd9;

  // byte lanes
  localparam logic [1:0] LANE_LOW  = 2'd0;
  localparam logic [1:0] LANE_HIGH = 2'd1;

  // branch conditions
  localparam logic [3:0] BC_ALWAYS = 4'd0;
  localparam logic [3:0] BC_Z      = 4'd1;
  localparam logic [3:0] BC_NZ     = 4'd2;
  localparam logic [3:0] BC_C      = 4'd3;
  localparam logic [3:0] BC_NC     = 4'd4;
  localparam logic [3:0] BC_N      = 4'd5;
  localparam logic [3:0] BC_NN     = 4'd6;
  localparam logic [3:0] BC_V      = 4'd7;
  localparam logic [3:0] BC_NV     = 4'd8;

  // flag selectors for setflag
  localparam logic [1:0] FS_C = 2'd0;
  localparam logic [1:0] FS_D = 2'd1;
  localparam logic [1:0] FS_I = 2'd2;
  localparam logic [1:0] FS_V = 2'd3;

  // ALU operations
  localparam logic [3:0] ALU_ADC = 4'd0;
  localparam logic [3:0] ALU_SBC = 4'd1;
  localparam logic [3:0] ALU_AND = 4'd2;
  localparam logic [3:0] ALU_ORA = 4'd3;
  localparam logic [3:0] ALU_EOR = 4'd4;
  localparam logic [3:0] ALU_CMP = 4'd5;
  localparam logic [3:0] ALU_CPX = 4'd6;
  localparam logic [3:0] ALU_CPY = 4'd7;
  localparam logic [3:0] ALU_BIT = 4'd8;

  // status bit positions
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_X = 4;
  localparam int FL_M = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [15:0] SP_RESET     = 16'h01FF;
  localparam logic [7:0]  STATUS_RESET = 8'h34;
  localparam logic [7:0]  STACK_PAGE   = 8'h01;

  typedef struct packed {
    logic [4:0] func;
    logic [7:0] bus_byte;
    logic [3:0] reg_src;
    logic [2:0] reg_dst;
    logic [1:0] byte_sel;
    logic [3:0] branch_cond;
    logic [1:0] flag_sel;
    logic [3:0] alu_op;
    logic       option;
  } uop_word_t;

  typedef struct packed {
    logic [15:0] a_value;
    logic [15:0] x_value;
    logic [15:0] y_value;
    logic [15:0] sp_value;
    logic [15:0] dp_value;
    logic [15:0] pc_value;
    logic [7:0]  pbr_value;
    logic [7:0]  dbr_value;
    logic [7:0]  status_value;
    logic        emulation_value;
    logic [23:0] address_value;
    logic [1:0]  timing_bits;
  } state_word_t;

endpackage

>>> design/cpu16_microop_datapath.sv
// ----------------------------------------------------------------------------
// cpu16_microop_datapath - micro-op datapath of a 16-bit 6502-family CPU
// Output: the result word for a micro-op is registered and appears the cycle after it is taken.
// Throughput: one micro-op per cycle while the result slot is not stalled; the single-pass step logic sets it.
// Reset: registers take their power-up values and the result slot empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cpu16_microop_datapath_assert.svh"

module cpu16_microop_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  cpu16_uop_pkg::uop_word_t   item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output cpu16_uop_pkg::state_word_t result
);

  import cpu16_uop_pkg::*;

  // Architectural state. Every accepted micro-op updates it in one pass and
  // the full snapshot after the step is captured into the result register.
  logic [15:0] acc, idx_x, idx_y, sp, dp, pc;
  logic [7:0]  dbr, pbr, flags;
  logic        emu, br_taken, pg_cross;
  logic [23:0] addr;

  logic [15:0] acc_next, idx_x_next, idx_y_next, sp_next, dp_next, pc_next;
  logic [7:0]  dbr_next, pbr_next, flags_next;
  logic        emu_next, br_taken_next, pg_cross_next;
  logic [23:0] addr_next;

  logic accept;

  // Take a new word whenever the result slot is empty or drains this cycle.
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  // {N, Z} of a value in 8- or 16-bit width
  function automatic logic [1:0] nz_of(input logic [15:0] v, input logic wide);
    if (wide) begin
      nz_of = {v[15], v == 16'h0000};
    end else begin
      nz_of = {v[7], v[7:0] == 8'h00};
    end
  endfunction

  // Merge one byte into the address latch; any lane above high means bank.
  function automatic logic [23:0] lane_merge(input logic [23:0] cur,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  b);
    if (lane == LANE_LOW) begin
      lane_merge = {cur[23:8], b};
    end else if (lane == LANE_HIGH) begin
      lane_merge = {cur[23:16], b, cur[7:0]};
    end else begin
      lane_merge = {b, cur[15:0]};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Step logic
  // --------------------------------------------------------------------------
  always_comb begin
    logic        acc_wide, idx_wide, wide, carry_in, cond;
    logic [15:0] src_v, dst_v, new_v, mask, sign, opnd, a_m, rhs, res, rv, diff;
    logic [16:0] sum;
    logic [1:0]  nz;
    logic [7:0]  p_tmp;

    acc_next      = acc;
    idx_x_next    = idx_x;
    idx_y_next    = idx_y;
    sp_next       = sp;
    dp_next       = dp;
    pc_next       = pc;
    dbr_next      = dbr;
    pbr_next      = pbr;
    flags_next    = flags;
    emu_next      = emu;
    br_taken_next = br_taken;
    pg_cross_next = pg_cross;
    addr_next     = addr;

    acc_wide = ~emu & ~flags[FL_M];
    idx_wide = ~emu & ~flags[FL_X];
    carry_in = flags[FL_C];

    // register read by source and destination selectors
    case (item.reg_src)
      RG_A:    src_v = acc;
      RG_X:    src_v = idx_x;
      RG_Y:    src_v = idx_y;
      RG_SP:   src_v = sp;
      RG_DP:   src_v = dp;
      default: src_v = 16'h0000;
    endcase
    case ({1'b0, item.reg_dst})
      RG_A:    dst_v = acc;
      RG_X:    dst_v = idx_x;
      RG_Y:    dst_v = idx_y;
      RG_SP:   dst_v = sp;
      RG_DP:   dst_v = dp;
      default: dst_v = 16'h0000;
    endcase

    // branch condition
    case (item.branch_cond)
      BC_ALWAYS: cond = 1'b1;
      BC_Z:      cond = flags[FL_Z];
      BC_NZ:     cond = ~flags[FL_Z];
      BC_C:      cond = flags[FL_C];
      BC_NC:     cond = ~flags[FL_C];
      BC_N:      cond = flags[FL_N];
      BC_NN:     cond = ~flags[FL_N];
      BC_V:      cond = flags[FL_V];
      BC_NV:     cond = ~flags[FL_V];
      default:   cond = 1'b0;
    endcase

    // ALU operands, shared by both widths
    wide  = (item.func == FN_ALU16);
    mask  = wide ? 16'hFFFF : 16'h00FF;
    sign  = wide ? 16'h8000 : 16'h0080;
    opnd  = wide ? {item.bus_byte, addr[7:0]} : {8'h00, item.bus_byte};
    a_m   = acc & mask;
    rhs   = (item.alu_op == ALU_SBC) ? (~opnd & mask) : opnd;
    sum   = {1'b0, a_m} + {1'b0, rhs} + {16'h0000, carry_in};
    case (item.alu_op)
      ALU_AND: res = a_m & opnd;
      ALU_ORA: res = a_m | opnd;
      ALU_EOR: res = a_m ^ opnd;
      default: res = sum[15:0] & mask;
    endcase
    case (item.alu_op)
      ALU_CPX: rv = idx_x & mask;
      ALU_CPY: rv = idx_y & mask;
      default: rv = a_m;
    endcase
    diff  = (rv - opnd) & mask;

    new_v = 16'h0000;
    nz    = 2'b00;
    p_tmp = 8'h00;

    case (item.func) inside
      FN_LOADREG: begin
        case (item.reg_src) inside
          RG_A, RG_X, RG_Y, RG_DP: begin
            if (item.byte_sel == LANE_LOW) begin
              new_v = {src_v[15:8], item.bus_byte};
              if (item.option && item.reg_src != RG_DP) begin
                nz = nz_of(new_v, 1'b0);
                flags_next[FL_N] = nz[1];
                flags_next[FL_Z] = nz[0];
              end
            end else begin
              new_v = {item.bus_byte, src_v[7:0]};
              nz = nz_of(new_v, 1'b1);
              flags_next[FL_N] = nz[1];
              flags_next[FL_Z] = nz[0];
            end
            case (item.reg_src)
              RG_A:    acc_next   = new_v;
              RG_X:    idx_x_next = new_v;
              RG_Y:    idx_y_next = new_v;
              default: dp_next    = new_v;
            endcase
          end
          RG_DBR: begin
            dbr_next = item.bus_byte;
            nz = nz_of({8'h00, item.bus_byte}, 1'b0);
            flags_next[FL_N] = nz[1];
            flags_next[FL_Z] = nz[0];
          end
          RG_PBR: pbr_next = item.bus_byte;
          RG_PCL: pc_next  = {pc[15:8], item.bus_byte};
          RG_PCH: pc_next  = {item.bus_byte, pc[7:0]};
          RG_P: begin
            flags_next = emu ? (item.bus_byte | 8'h30) : item.bus_byte;
          end
          default: ;
        endcase
      end

      FN_BRCOND: br_taken_next = cond;

      FN_BRANCH: begin
        if (item.option) begin
          pc_next = pc + addr[15:0];
        end else begin
          new_v = pc + {{8{item.bus_byte[7]}}, item.bus_byte};
          pc_next = new_v;
          pg_cross_next = (new_v[15:8] != pc[15:8]);
        end
      end

      FN_SETADDR: begin
        addr_next = lane_merge(addr, item.byte_sel, item.bus_byte);
        if (item.byte_sel == LANE_HIGH && item.option) begin
          addr_next = {dbr, addr_next[15:0]};
        end
      end

      FN_MODADDR: addr_next = addr + (item.option ? 24'h000001 : 24'hFFFFFF);

      FN_MODSP: begin
        if (emu) begin
          sp_next = {STACK_PAGE, sp[7:0] + (item.option ? 8'h01 : 8'hFF)};
        end else begin
          sp_next = sp + (item.option ? 16'h0001 : 16'hFFFF);
        end
      end

      FN_MODPC: pc_next = pc + (item.option ? 16'h0001 : 16'hFFFF);

      FN_INCDEC: begin
        if (item.reg_src <= RG_DP) begin
          wide = (item.reg_src == RG_A) ? acc_wide : idx_wide;
          if (wide) begin
            new_v = src_v + (item.option ? 16'h0001 : 16'hFFFF);
          end else begin
            new_v = {src_v[15:8], src_v[7:0] + (item.option ? 8'h01 : 8'hFF)};
          end
          nz = nz_of(new_v, wide);
          flags_next[FL_N] = nz[1];
          flags_next[FL_Z] = nz[0];
          case (item.reg_src)
            RG_A:    acc_next   = new_v;
            RG_X:    idx_x_next = new_v;
            RG_Y:    idx_y_next = new_v;
            RG_SP:   sp_next    = new_v;
            default: dp_next    = new_v;
          endcase
        end
      end

      FN_SETFLAG: begin
        case (item.flag_sel)
          FS_C:    flags_next[FL_C] = item.option;
          FS_D:    flags_next[FL_D] = item.option;
          FS_I:    flags_next[FL_I] = item.option;
          default: flags_next[FL_V] = item.option;
        endcase
      end

      FN_MASK: begin
        p_tmp = item.option ? (flags | item.bus_byte) : (flags & ~item.bus_byte);
        flags_next = emu ? (p_tmp | 8'h30) : p_tmp;
      end

      FN_XCE: begin
        flags_next[FL_C] = emu;
        emu_next = flags[FL_C];
      end

      FN_XFER: begin
        if (item.reg_src <= RG_DP && {1'b0, item.reg_dst} <= RG_DP) begin
          if ({1'b0, item.reg_dst} == RG_SP) begin
            sp_next = src_v;
          end else begin
            if ({1'b0, item.reg_dst} == RG_DP) begin
              wide = 1'b1;
            end else if ({1'b0, item.reg_dst} == RG_A) begin
              wide = (item.reg_src == RG_SP) || (item.reg_src == RG_DP) || acc_wide;
            end else begin
              wide = idx_wide;
            end
            new_v = wide ? src_v : {dst_v[15:8], src_v[7:0]};
            nz = nz_of(new_v, wide);
            flags_next[FL_N] = nz[1];
            flags_next[FL_Z] = nz[0];
            case ({1'b0, item.reg_dst})
              RG_A:    acc_next   = new_v;
              RG_X:    idx_x_next = new_v;
              RG_Y:    idx_y_next = new_v;
              default: dp_next    = new_v;
            endcase
          end
        end
      end

      FN_PCADDR, FN_ADDRPC: begin
        if (item.func == FN_ADDRPC) begin
          addr_next = lane_merge(addr, item.byte_sel, item.bus_byte);
        end
        pc_next = addr_next[15:0];
        if (item.option) begin
          pbr_next = addr_next[23:16];
        end
      end

      FN_ALU8, FN_ALU16: begin
        case (item.alu_op) inside
          ALU_ADC, ALU_SBC, ALU_AND, ALU_ORA, ALU_EOR: begin
            if (item.alu_op == ALU_ADC || item.alu_op == ALU_SBC) begin
              flags_next[FL_V] = |((~(a_m ^ rhs) & (a_m ^ res)) & sign);
              flags_next[FL_C] = wide ? sum[16] : sum[8];
            end
            flags_next[FL_Z] = (res == 16'h0000);
            flags_next[FL_N] = |(res & sign);
            acc_next = wide ? res : {acc[15:8], res[7:0]};
          end
          ALU_CMP, ALU_CPX, ALU_CPY: begin
            flags_next[FL_C] = (rv >= opnd);
            flags_next[FL_Z] = (diff == 16'h0000);
            flags_next[FL_N] = |(diff & sign);
          end
          ALU_BIT: flags_next[FL_Z] = ((a_m & opnd) == 16'h0000);
          default: ;
        endcase
      end

      default: ;
    endcase

    // Mode forcing after every step: emulation pins M, X and the stack page,
    // and 8-bit index mode clears the index high bytes.
    if (emu_next) begin
      flags_next[FL_M] = 1'b1;
      flags_next[FL_X] = 1'b1;
      sp_next = {STACK_PAGE, sp_next[7:0]};
    end
    if (flags_next[FL_X]) begin
      idx_x_next = {8'h00, idx_x_next[7:0]};
      idx_y_next = {8'h00, idx_y_next[7:0]};
    end
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= 16'h0000;
      idx_x        <= 16'h0000;
      idx_y        <= 16'h0000;
      sp           <= SP_RESET;
      dp           <= 16'h0000;
      pc           <= 16'h0000;
      dbr          <= 8'h00;
      pbr          <= 8'h00;
      flags        <= STATUS_RESET;
      emu          <= 1'b1;
      addr         <= 24'h000000;
      br_taken     <= 1'b0;
      pg_cross     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        acc          <= acc_next;
        idx_x        <= idx_x_next;
        idx_y        <= idx_y_next;
        sp           <= sp_next;
        dp           <= dp_next;
        pc           <= pc_next;
        dbr          <= dbr_next;
        pbr          <= pbr_next;
        flags        <= flags_next;
        emu          <= emu_next;
        addr         <= addr_next;
        br_taken     <= br_taken_next;
        pg_cross     <= pg_cross_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        // drop the word once taken
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload: capture the post-step snapshot; hold it while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      result.a_value         <= acc_next;
      result.x_value         <= idx_x_next;
      result.y_value         <= idx_y_next;
      result.sp_value        <= sp_next;
      result.dp_value        <= dp_next;
      result.pc_value        <= pc_next;
      result.pbr_value       <= pbr_next;
      result.dbr_value       <= dbr_next;
      result.status_value    <= flags_next;
      result.emulation_value <= emu_next;
      result.address_value   <= addr_next;
      result.timing_bits     <= {pg_cross_next, br_taken_next};
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  logic        emu_forced_ok, idx_high_clear;
  logic [63:0] arch_snap;

  assign emu_forced_ok  = result.status_value[FL_M] && result.status_value[FL_X] &&
                          (result.sp_value[15:8] == STACK_PAGE);
  assign idx_high_clear = (result.x_value[15:8] == 8'h00) && (result.y_value[15:8] == 8'h00);
  assign arch_snap      = {acc, flags, pc, addr};

  `CPU16_ASSERT_NOW(a_emu_forcing, clk, rst, result_valid && result.emulation_value, emu_forced_ok)
  `CPU16_ASSERT_NOW(a_index_narrow, clk, rst, result_valid && result.status_value[FL_X], idx_high_clear)
  `CPU16_ASSERT_NEXT(a_accept_fills, clk, rst, item_valid && !item_stall, result_valid)
  `CPU16_ASSERT_NEXT(a_stall_holds_state, clk, rst, item_stall, $stable(arch_snap))

endmodule

>>> dv/cpu16_microop_checker.sv
// ----------------------------------------------------------------------------
// cpu16 micro-op datapath checker
// Watches both channels, predicts each result word from the accepted micro-op
// words and compares the two field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu16_microop_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  cpu16_uop_pkg::uop_word_t   item,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  cpu16_uop_pkg::state_word_t result,
  output int                         error_count,
  output int                         pending_words
);

  import cpu16_uop_pkg::*;

  // predicted architectural state
  logic [15:0] acc, idx_x, idx_y, sp, dp, pc;
  logic [7:0]  pbr, dbr, flags;
  logic        emu, taken, crossed;
  logic [23:0] addr_latch;

  state_word_t expected_states[$];
  int          mismatches = 0;
  int          outstanding = 0;

  assign error_count   = mismatches;
  assign pending_words = outstanding;

  function automatic logic [15:0] read_gpr(logic [3:0] sel);
    case (sel)
      RG_A:    return acc;
      RG_X:    return idx_x;
      RG_Y:    return idx_y;
      RG_SP:   return sp;
      default: return dp;
    endcase
  endfunction

  function automatic void write_gpr(logic [3:0] sel, logic [15:0] v);
    case (sel)
      RG_A:    acc = v;
      RG_X:    idx_x = v;
      RG_Y:    idx_y = v;
      RG_SP:   sp = v;
      default: dp = v;
    endcase
  endfunction

  function automatic void set_nz(logic [15:0] v, logic wide);
    if (wide) begin
      flags[FL_Z] = (v == 16'h0000);
      flags[FL_N] = v[15];
    end else begin
      flags[FL_Z] = (v[7:0] == 8'h00);
      flags[FL_N] = v[7];
    end
  endfunction

  // emulation keeps M and X high on any status write
  function automatic void load_status(logic [7:0] p);
    flags = p;
    if (emu) begin
      flags[FL_M] = 1'b1;
      flags[FL_X] = 1'b1;
    end
  endfunction

  function automatic void latch_byte(logic [1:0] lane, logic [7:0] fd);
    case (lane)
      LANE_LOW:  addr_latch[7:0]   = fd;
      LANE_HIGH: addr_latch[15:8]  = fd;
      default:   addr_latch[23:16] = fd;
    endcase
  endfunction

  function automatic logic acc16();
    return !emu && !flags[FL_M];
  endfunction

  function automatic logic idx16();
    return !emu && !flags[FL_X];
  endfunction

  function automatic void check_field(string name, logic [23:0] want_v, logic [23:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic step_microop(input uop_word_t w, output state_word_t s);
    logic [15:0] v, d_old, old_pc, mask, sign, a, opnd, rhs, res, rv;
    logic [16:0] sum;
    logic [3:0]  dst;
    logic        wide, write_acc, t;
    dst = {1'b0, w.reg_dst};
    case (w.func)
      FN_LOADREG: begin
        case (w.reg_src)
          RG_A, RG_X, RG_Y, RG_DP: begin
            v = read_gpr(w.reg_src);
            if (w.byte_sel == LANE_LOW) begin
              v = {v[15:8], w.bus_byte};
              write_gpr(w.reg_src, v);
              if (w.option && w.reg_src != RG_DP) set_nz(v, 1'b0);
            end else begin
              v = {w.bus_byte, v[7:0]};
              write_gpr(w.reg_src, v);
              set_nz(v, 1'b1);
            end
          end
          RG_DBR: begin
            dbr = w.bus_byte;
            set_nz({8'h00, w.bus_byte}, 1'b0);
          end
          RG_PBR: pbr = w.bus_byte;
          RG_PCL: pc[7:0] = w.bus_byte;
          RG_PCH: pc[15:8] = w.bus_byte;
          RG_P:   load_status(w.bus_byte);
          default: ;
        endcase
      end
      FN_BRCOND: begin
        case (w.branch_cond)
          BC_ALWAYS: taken = 1'b1;
          BC_Z:      taken = flags[FL_Z];
          BC_NZ:     taken = !flags[FL_Z];
          BC_C:      taken = flags[FL_C];
          BC_NC:     taken = !flags[FL_C];
          BC_N:      taken = flags[FL_N];
          BC_NN:     taken = !flags[FL_N];
          BC_V:      taken = flags[FL_V];
          BC_NV:     taken = !flags[FL_V];
          default:   taken = 1'b0;
        endcase
      end
      FN_BRANCH: begin
        if (w.option) begin
          pc = pc + addr_latch[15:0];
        end else begin
          old_pc  = pc;
          pc      = pc + {{8{w.bus_byte[7]}}, w.bus_byte};
          crossed = (old_pc[15:8] != pc[15:8]);
        end
      end
      FN_SETADDR: begin
        latch_byte(w.byte_sel, w.bus_byte);
        if (w.byte_sel == LANE_HIGH && w.option) addr_latch[23:16] = dbr;
      end
      FN_MODADDR: addr_latch = w.option ? addr_latch + 24'd1 : addr_latch - 24'd1;
      FN_MODSP: begin
        if (emu) sp = {STACK_PAGE, w.option ? sp[7:0] + 8'd1 : sp[7:0] - 8'd1};
        else     sp = w.option ? sp + 16'd1 : sp - 16'd1;
      end
      FN_MODPC: pc = w.option ? pc + 16'd1 : pc - 16'd1;
      FN_INCDEC: begin
        if (w.reg_src <= RG_DP) begin
          wide = (w.reg_src == RG_A) ? acc16() : idx16();
          v = read_gpr(w.reg_src);
          if (wide) v = w.option ? v + 16'd1 : v - 16'd1;
          else      v[7:0] = w.option ? v[7:0] + 8'd1 : v[7:0] - 8'd1;
          write_gpr(w.reg_src, v);
          set_nz(v, wide);
        end
      end
      FN_SETFLAG: begin
        case (w.flag_sel)
          FS_C:    flags[FL_C] = w.option;
          FS_D:    flags[FL_D] = w.option;
          FS_I:    flags[FL_I] = w.option;
          default: flags[FL_V] = w.option;
        endcase
      end
      FN_MASK: load_status(w.option ? (flags | w.bus_byte) : (flags & ~w.bus_byte));
      FN_XCE: begin
        t           = flags[FL_C];
        flags[FL_C] = emu;
        emu         = t;
      end
      FN_XFER: begin
        if (w.reg_src <= RG_DP && dst <= RG_DP) begin
          v = read_gpr(w.reg_src);
          if (dst == RG_SP) begin
            sp = v;
          end else begin
            if (dst == RG_DP)     wide = 1'b1;
            else if (dst == RG_A) wide = (w.reg_src == RG_SP || w.reg_src == RG_DP || acc16());
            else                  wide = idx16();
            d_old = read_gpr(dst);
            if (!wide) v = {d_old[15:8], v[7:0]};
            write_gpr(dst, v);
            set_nz(v, wide);
          end
        end
      end
      FN_PCADDR, FN_ADDRPC: begin
        if (w.func == FN_ADDRPC) latch_byte(w.byte_sel, w.bus_byte);
        pc = addr_latch[15:0];
        if (w.option) pbr = addr_latch[23:16];
      end
      FN_ALU8, FN_ALU16: begin
        wide      = (w.func == FN_ALU16);
        mask      = wide ? 16'hFFFF : 16'h00FF;
        sign      = wide ? 16'h8000 : 16'h0080;
        opnd      = wide ? {w.bus_byte, addr_latch[7:0]} : {8'h00, w.bus_byte};
        a         = acc & mask;
        res       = 16'h0000;
        write_acc = 1'b0;
        case (w.alu_op)
          ALU_ADC, ALU_SBC: begin
            rhs         = (w.alu_op == ALU_SBC) ? (~opnd & mask) : opnd;
            sum         = {1'b0, a} + {1'b0, rhs} + {16'h0000, flags[FL_C]};
            res         = sum[15:0] & mask;
            flags[FL_V] = ((~(a ^ rhs) & (a ^ res) & sign) != 16'h0000);
            flags[FL_C] = wide ? sum[16] : sum[8];
            write_acc   = 1'b1;
          end
          ALU_AND: begin res = a & opnd; write_acc = 1'b1; end
          ALU_ORA: begin res = a | opnd; write_acc = 1'b1; end
          ALU_EOR: begin res = a ^ opnd; write_acc = 1'b1; end
          ALU_CMP, ALU_CPX, ALU_CPY: begin
            rv = (w.alu_op == ALU_CMP) ? acc : ((w.alu_op == ALU_CPX) ? idx_x : idx_y);
            rv = rv & mask;
            res = (rv - opnd) & mask;
            flags[FL_C] = (rv >= opnd);
            flags[FL_Z] = (res == 16'h0000);
            flags[FL_N] = ((res & sign) != 16'h0000);
          end
          ALU_BIT: flags[FL_Z] = ((a & opnd) == 16'h0000);
          default: ;
        endcase
        if (write_acc) begin
          flags[FL_Z] = (res == 16'h0000);
          flags[FL_N] = ((res & sign) != 16'h0000);
          acc = wide ? res : {acc[15:8], res[7:0]};
        end
      end
      default: ;
    endcase

    // mode forcing after every step
    if (emu) begin
      flags[FL_M] = 1'b1;
      flags[FL_X] = 1'b1;
      sp[15:8]    = STACK_PAGE;
    end
    if (flags[FL_X]) begin
      idx_x[15:8] = 8'h00;
      idx_y[15:8] = 8'h00;
    end

    s.a_value         = acc;
    s.x_value         = idx_x;
    s.y_value         = idx_y;
    s.sp_value        = sp;
    s.dp_value        = dp;
    s.pc_value        = pc;
    s.pbr_value       = pbr;
    s.dbr_value       = dbr;
    s.status_value    = flags;
    s.emulation_value = emu;
    s.address_value   = addr_latch;
    s.timing_bits     = {crossed, taken};
  endtask

  always @(posedge clk) begin : watch_channels
    state_word_t want;
    if (rst) begin
      acc        = 16'h0000;
      idx_x      = 16'h0000;
      idx_y      = 16'h0000;
      sp         = SP_RESET;
      dp         = 16'h0000;
      pc         = 16'h0000;
      pbr        = 8'h00;
      dbr        = 8'h00;
      flags      = STATUS_RESET;
      emu        = 1'b1;
      addr_latch = 24'h000000;
      taken      = 1'b0;
      crossed    = 1'b0;
      expected_states.delete();
    end else begin
      // compare before predicting: a word taken at this edge cannot leave yet
      if (result_valid && !result_stall) begin
        if (expected_states.size() == 0) begin
          $error("result word with no micro-op outstanding");
          mismatches++;
        end else begin
          want = expected_states.pop_front();
          check_field("a_value", 24'(want.a_value), 24'(result.a_value));
          check_field("x_value", 24'(want.x_value), 24'(result.x_value));
          check_field("y_value", 24'(want.y_value), 24'(result.y_value));
          check_field("sp_value", 24'(want.sp_value), 24'(result.sp_value));
          check_field("dp_value", 24'(want.dp_value), 24'(result.dp_value));
          check_field("pc_value", 24'(want.pc_value), 24'(result.pc_value));
          check_field("pbr_value", 24'(want.pbr_value), 24'(result.pbr_value));
          check_field("dbr_value", 24'(want.dbr_value), 24'(result.dbr_value));
          check_field("status_value", 24'(want.status_value), 24'(result.status_value));
          check_field("emulation_value", 24'(want.emulation_value),
                      24'(result.emulation_value));
          check_field("address_value", want.address_value, result.address_value);
          check_field("timing_bits", 24'(want.timing_bits), 24'(result.timing_bits));
        end
      end
      if (item_valid && !item_stall) begin
        step_microop(item, want);
        expected_states.push_back(want);
      end
    end
    outstanding <= expected_states.size();
  end

endmodule

>>> dv/tb_cpu16_microop_datapath.sv
// ----------------------------------------------------------------------------
// cpu16 micro-op datapath testbench
// Drives directed and random micro-op words with random idle bursts on both
// channels; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cpu16_microop_datapath;
  import cpu16_uop_pkg::*;

  localparam int WORD_TARGET = 1050;   // micro-op words to send in total
  localparam int QUIET_WORDS = 150;    // final words sent with no idling
  localparam int CYCLE_LIMIT = 100000; // hang guard
  localparam int DRAIN_CYCLES = 4;     // idle wait after the last drain; results are registered at accept

  // destination and lane codes the package leaves unnamed
  localparam logic [2:0] DST_A      = 3'd0;
  localparam logic [2:0] DST_SP     = 3'd3;
  localparam logic [1:0] LANE_BANK  = 2'd2;
  localparam logic [1:0] LANE_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  uop_word_t   item;
  logic        result_valid;
  logic        result_stall;
  state_word_t result;

  int error_count;
  int pending_words;
  int words_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int free_left = 0;
  logic quiet_tail = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cpu16_microop_datapath DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  cpu16_microop_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .error_count   (error_count),
    .pending_words (pending_words)
  );

  // Hang guard: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result-side backpressure: random stall bursts separated by free stretches,
  // some of them long. Drop all stalls in the quiet tail.
  always @(negedge clk) begin
    if (rst || quiet_tail) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (free_left > 0) begin
      result_stall <= 1'b0;
      free_left    <= free_left - 1;
    end else begin
      result_stall <= 1'b0;
      stall_left   <= $urandom_range(1, 4);
      free_left    <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 5);
    end
  end

  function automatic uop_word_t pack_uop(logic [4:0] fn, logic [7:0] fd, logic [3:0] src,
                                         logic [2:0] dst, logic [1:0] lane,
                                         logic [3:0] cond, logic [1:0] fsel,
                                         logic [3:0] aop, logic opt);
    uop_word_t w;
    w.func        = fn;
    w.bus_byte    = fd;
    w.reg_src     = src;
    w.reg_dst     = dst;
    w.byte_sel    = lane;
    w.branch_cond = cond;
    w.flag_sel    = fsel;
    w.alu_op      = aop;
    w.option      = opt;
    return w;
  endfunction

  // Mostly in-range selectors; one word in ten keeps raw bits so unused
  // codes and every field bit get exercised.
  function automatic uop_word_t random_word();
    uop_word_t w;
    w.func        = 5'($urandom_range(0, 31));
    w.bus_byte    = 8'($urandom);
    w.reg_src     = 4'($urandom_range(0, 15));
    w.reg_dst     = 3'($urandom_range(0, 7));
    w.byte_sel    = 2'($urandom_range(0, 3));
    w.branch_cond = 4'($urandom_range(0, 15));
    w.flag_sel    = 2'($urandom_range(0, 3));
    w.alu_op      = 4'($urandom_range(0, 15));
    w.option      = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) != 0) begin
      w.func        = 5'($urandom_range(0, 16));
      w.reg_src     = 4'($urandom_range(0, 9));
      w.reg_dst     = 3'($urandom_range(0, 4));
      w.branch_cond = 4'($urandom_range(0, 8));
      w.alu_op      = 4'($urandom_range(0, 8));
    end
    return w;
  endfunction

  // Present one word at the falling edge and hold it until accepted. Outside
  // the quiet tail, idle for a random burst first now and then.
  task automatic send_word(input uop_word_t w);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Lower valid and hold off until every outstanding result has arrived.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_directed();
    logic [3:0] alu_pick [4];
    alu_pick = '{ALU_ADC, ALU_SBC, ALU_CMP, ALU_BIT};
    send_word(pack_uop(FN_NONE, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    // byte loads in emulation: NZ on low byte, wide NZ on high byte
    send_word(pack_uop(FN_LOADREG, 8'hFF, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b1));
    send_word(pack_uop(FN_LOADREG, 8'h80, RG_A, DST_A, LANE_HIGH, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    // X high byte must be cleared while the X flag is forced
    send_word(pack_uop(FN_LOADREG, 8'hFF, RG_X, DST_A, LANE_HIGH, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    // status load of zero keeps M and X in emulation
    send_word(pack_uop(FN_LOADREG, 8'h00, RG_P, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    // stack wraps inside page one
    send_word(pack_uop(FN_MODSP, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b1));
    // enter native mode and open both 16-bit widths
    send_word(pack_uop(FN_SETFLAG, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    send_word(pack_uop(FN_XCE, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    send_word(pack_uop(FN_MASK, 8'h30, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    send_word(pack_uop(FN_LOADREG, 8'hFF, RG_X, DST_A, LANE_HIGH, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    send_word(pack_uop(FN_INCDEC, 8'h00, RG_X, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b1));
    // unused register selector changes nothing
    send_word(pack_uop(FN_INCDEC, 8'h00, RG_PCL, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b1));
    send_word(pack_uop(FN_XFER, 8'h00, RG_X, DST_SP, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    send_word(pack_uop(FN_LOADREG, 8'h80, RG_DBR, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    // high lane with bank taken from DBR, then the spare lane acting as bank
    send_word(pack_uop(FN_SETADDR, 8'h12, RG_A, DST_A, LANE_HIGH, BC_ALWAYS, FS_C, ALU_ADC, 1'b1));
    send_word(pack_uop(FN_SETADDR, 8'hFF, RG_A, DST_A, LANE_SPARE, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    send_word(pack_uop(FN_MODADDR, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    // taken branch, backward short branch crossing a page, then long branch
    send_word(pack_uop(FN_BRCOND, 8'h00, RG_A, DST_A, LANE_LOW, BC_N, FS_C, ALU_ADC, 1'b0));
    send_word(pack_uop(FN_BRANCH, 8'h80, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    send_word(pack_uop(FN_BRANCH, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b1));
    send_word(pack_uop(FN_MODPC, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    send_word(pack_uop(FN_ADDRPC, 8'h34, RG_A, DST_A, LANE_BANK, BC_ALWAYS, FS_C, ALU_ADC, 1'b1));
    send_word(pack_uop(FN_PCADDR, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
    // ALU ops alternating 16-bit and 8-bit widths
    foreach (alu_pick[i])
      send_word(pack_uop((i % 2 == 0) ? FN_ALU16 : FN_ALU8, 8'h7F, RG_A, DST_A, LANE_LOW,
                         BC_ALWAYS, FS_C, alu_pick[i], 1'b0));
    // back to emulation: forcing trims SP and the index high bytes
    send_word(pack_uop(FN_SETFLAG, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b1));
    send_word(pack_uop(FN_XCE, 8'h00, RG_A, DST_A, LANE_LOW, BC_ALWAYS, FS_C, ALU_ADC, 1'b0));
  endtask

  // Random part: mostly single random words, with mode-switch, branch and
  // address-then-ALU sequences mixed in so native and 16-bit paths get deep
  // coverage instead of sitting in emulation.
  task automatic run_random();
    uop_word_t w;
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= WORD_TARGET - QUIET_WORDS) quiet_tail <= 1'b1;
      case ($urandom_range(0, 19))
        0: begin
          send_word(pack_uop(FN_SETFLAG, 8'($urandom), RG_A, DST_A, LANE_LOW, BC_ALWAYS,
                             FS_C, ALU_ADC, 1'b0));
          send_word(pack_uop(FN_XCE, 8'($urandom), RG_A, DST_A, LANE_LOW, BC_ALWAYS,
                             FS_C, ALU_ADC, 1'b0));
          send_word(pack_uop(FN_MASK, 8'($urandom) & 8'h30, RG_A, DST_A, LANE_LOW, BC_ALWAYS,
                             FS_C, ALU_ADC, 1'b0));
        end
        1: begin
          send_word(pack_uop(FN_SETFLAG, 8'($urandom), RG_A, DST_A, LANE_LOW, BC_ALWAYS,
                             FS_C, ALU_ADC, 1'b1));
          send_word(pack_uop(FN_XCE, 8'($urandom), RG_A, DST_A, LANE_LOW, BC_ALWAYS,
                             FS_C, ALU_ADC, 1'b0));
        end
        2, 3: begin
          w = random_word();
          w.func        = FN_BRCOND;
          w.branch_cond = 4'($urandom_range(0, 8));
          send_word(w);
          w = random_word();
          w.func = FN_BRANCH;
          send_word(w);
        end
        4: begin
          w = random_word();
          w.func     = FN_SETADDR;
          w.byte_sel = LANE_LOW;
          send_word(w);
          w = random_word();
          w.func   = FN_ALU16;
          w.alu_op = 4'($urandom_range(0, 8));
          send_word(w);
        end
        default: send_word(random_word());
      endcase
    end
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    // let every directed result come home before the random part
    drain_results();
    run_random();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> cpu16_microop_datapath.f
+incdir+design
design/cpu16_uop_pkg.sv
design/cpu16_microop_datapath.sv
dv/cpu16_microop_checker.sv
dv/tb_cpu16_microop_datapath.sv
